>>> src/stg_pkg.sv
// Shared types, constants and the quarter-wave sine table function for the tone generator.
`default_nettype none

package stg_pkg;

    localparam int CNT_W      = 7;
    localparam int PHASE_W    = 32;
    localparam int SAMPLE_W   = 32;
    localparam int AMP_W      = 17;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int ENTRY_W    = 32;
    localparam int PROD_W     = ENTRY_W + AMP_W;

    localparam int MAX_PERIOD_DEF      = 64;
    localparam int SINE_TABLE_BITS_DEF = 10;

    localparam logic [CFG_IDX_W-1:0] REG_PHASE_INC = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE = 1'b1;

    localparam logic [AMP_W-1:0] AMP_RESET = 17'd65536;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef struct packed {
        logic             valid;
        logic [CNT_W-1:0] count;
    } t_cnt_req;

    // sin(pi/2 * k / 2^bits) as unsigned Q1.31, Taylor series in Q2.30.
    // Evaluated at elaboration only.
    function automatic logic [ENTRY_W-1:0] quarter_entry(input int unsigned k,
                                                          input int unsigned bits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] half;
        longint      sum;
        logic [63:0] v;
        half = (64'd1 << bits) >> 1;
        x    = (HALF_PI_Q30 * 64'(k) + half) >> bits;
        x2   = (x * x) >> 30;
        sum  = longint'(x);
        term = x;
        term = ((term * x2) >> 30) / 64'd6;   sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd20;  sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd42;  sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd72;  sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd110; sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd156; sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd210; sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd272; sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd342; sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd420; sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd506; sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd600; sum = sum + longint'(term);
        if (sum < 0) begin
            sum = 0;
        end
        v = 64'(sum) << 1;
        if (v > 64'h8000_0000) begin
            v = 64'h8000_0000;
        end
        return v[ENTRY_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> src/stg_front.sv
// Request intake: clamps the sample count and drops empty requests before the queue.
`default_nettype none

module stg_front
    import stg_pkg::*;
#(
    parameter int MAX_PERIOD = MAX_PERIOD_DEF
) (
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire logic [CNT_W-1:0] i_sample_count,
    input  wire logic             i_q_full,
    output t_cnt_req              o_push
);

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PERIOD);

    logic [CNT_W-1:0] w_count;

    assign w_count    = (i_sample_count > MAX_CNT) ? MAX_CNT : i_sample_count;
    assign o_in_ready = !i_q_full;

    // zero-count requests are taken but produce nothing
    assign o_push.valid = i_in_valid && !i_q_full && (w_count != '0);
    assign o_push.count = w_count;

endmodule

`default_nettype wire

>>> src/stg_queue.sv
// Two-entry request queue between intake and the sample engine.
`default_nettype none

module stg_queue
    import stg_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_cnt_req i_push,
    output logic          o_full,
    output t_cnt_req      o_head,
    input  wire logic     i_pop
);

    logic [CNT_W-1:0] r_mem [2];
    logic             r_wptr;
    logic             r_rptr;
    logic [1:0]       r_cnt;
    logic [1:0]       n_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_full       = (r_cnt == 2'd2);
    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.count = r_mem[r_rptr];

    assign w_push = i_push.valid && !o_full;
    assign w_pop  = i_pop && o_head.valid;

    always_comb begin
        n_cnt = r_cnt;
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) begin
                r_wptr <= !r_wptr;
            end
            if (w_pop) begin
                r_rptr <= !r_rptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_push.count;
        end
    end

endmodule

`default_nettype wire

>>> src/stg_back.sv
// Sample engine: phase accumulator, quarter-wave lookup, amplitude multiply, round and saturate.
`default_nettype none

module stg_back
    import stg_pkg::*;
#(
    parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cnt_req              i_req,
    output logic                       o_pop,
    input  wire logic [PHASE_W-1:0]    i_phase_inc,
    input  wire logic [AMP_W-1:0]      i_amplitude,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic signed [SAMPLE_W-1:0] o_sample,
    output logic                       o_last_sample
);

    localparam int                   ADDR_W   = SINE_TABLE_BITS + 1;
    localparam int                   QTR_SIZE = 1 << SINE_TABLE_BITS;
    localparam logic [ADDR_W-1:0]    QTR_ADDR = ADDR_W'(QTR_SIZE);

    // quarter-wave ROM contents, fixed at elaboration
    logic [ENTRY_W-1:0] w_qtab [QTR_SIZE+1];

    for (genvar k = 0; k <= QTR_SIZE; k++) begin : g_qtab
        assign w_qtab[k] = quarter_entry(k, SINE_TABLE_BITS);
    end

    logic [CNT_W-1:0]   r_left;
    logic [PHASE_W-1:0] r_phase;
    logic               w_en;
    logic               w_issue;
    logic [1:0]         w_quad;
    logic [SINE_TABLE_BITS-1:0] w_idx;
    logic [ADDR_W-1:0]  w_addr;

    // stage 1: table read
    logic               r_v1;
    logic [ENTRY_W-1:0] r_entry;
    logic               r_neg1;
    logic               r_last1;
    // stage 2: scale
    logic               r_v2;
    logic [PROD_W-1:0]  r_prod;
    logic               r_neg2;
    logic               r_last2;
    // stage 3: output register
    logic               r_v3;
    logic [SAMPLE_W-1:0] r_sample;
    logic               r_last3;

    logic [PROD_W:0]    w_round;
    logic [33:0]        w_mag;
    logic [SAMPLE_W-1:0] w_pos;
    logic [SAMPLE_W-1:0] w_negmag;
    logic [SAMPLE_W-1:0] w_result;

    // whole pipeline moves when the output slot is free or being drained
    assign w_en    = !r_v3 || i_out_ready;
    assign w_issue = (r_left != '0) && w_en;
    assign o_pop   = (r_left == '0) && i_req.valid;

    assign w_quad = r_phase[PHASE_W-1 -: 2];
    assign w_idx  = r_phase[PHASE_W-3 -: SINE_TABLE_BITS];
    // odd quadrants read the table mirrored
    assign w_addr = w_quad[0] ? (QTR_ADDR - {1'b0, w_idx}) : {1'b0, w_idx};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left  <= '0;
            r_phase <= '0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
        end else begin
            if (o_pop) begin
                r_left <= i_req.count;
            end else if (w_issue) begin
                r_left  <= r_left - CNT_W'(1);
                r_phase <= r_phase + i_phase_inc;
            end
            if (w_en) begin
                r_v1 <= w_issue;
                r_v2 <= r_v1;
                r_v3 <= r_v2;
            end
        end
    end

    assign w_round  = {1'b0, r_prod} + (PROD_W+1)'(32768);
    assign w_mag    = w_round[PROD_W -: 34];
    assign w_pos    = (w_mag > 34'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : w_mag[SAMPLE_W-1:0];
    assign w_negmag = (w_mag > 34'h0_8000_0000) ? 32'h8000_0000 : w_mag[SAMPLE_W-1:0];
    assign w_result = r_neg2 ? (32'd0 - w_negmag) : w_pos;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_entry  <= w_qtab[w_addr];
            r_neg1   <= w_quad[1];
            r_last1  <= (r_left == CNT_W'(1));
            r_prod   <= {{AMP_W{1'b0}}, r_entry} * {{ENTRY_W{1'b0}}, i_amplitude};
            r_neg2   <= r_neg1;
            r_last2  <= r_last1;
            r_sample <= w_result;
            r_last3  <= r_last2;
        end
    end

    assign o_out_valid   = r_v3;
    assign o_sample      = signed'(r_sample);
    assign o_last_sample = r_last3;

endmodule

`default_nettype wire

>>> src/sine_tone_generator.sv
// Sine tone generator: DDS phase accumulator with quarter-wave table, amplitude scaling, int32 out.
// Each request asks for sample_count samples (clamped to MAX_PERIOD; a count of zero is taken
// and yields nothing). Samples come out one per cycle within a request while the sink is ready;
// between requests the sample engine pauses to load the next count from a two-entry queue.
// Each sample passes through registered stages in order: table ROM read, amplitude multiply,
// round and saturate. The phase carries over between requests.
// Write phase_increment and amplitude only while the block is idle; amplitude resets to 1.0.
`default_nettype none

module sine_tone_generator
    import stg_pkg::*;
#(
    parameter int MAX_PERIOD      = MAX_PERIOD_DEF,
    parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [CNT_W-1:0]      i_sample_count,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic signed [SAMPLE_W-1:0] o_sample,
    output logic                       o_last_sample,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [PHASE_W-1:0] r_phase_inc;
    logic [AMP_W-1:0]   r_amplitude;
    t_cnt_req           w_push;
    t_cnt_req           w_head;
    logic               w_full;
    logic               w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_inc <= '0;
            r_amplitude <= AMP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_PHASE_INC: r_phase_inc <= i_cfg_data[PHASE_W-1:0];
                REG_AMPLITUDE: r_amplitude <= i_cfg_data[AMP_W-1:0];
                default: ;
            endcase
        end
    end

    stg_front #(
        .MAX_PERIOD (MAX_PERIOD)
    ) u_front (
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_sample_count (i_sample_count),
        .i_q_full       (w_full),
        .o_push         (w_push)
    );

    stg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_full  (w_full),
        .o_head  (w_head),
        .i_pop   (w_pop)
    );

    stg_back #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (w_head),
        .o_pop         (w_pop),
        .i_phase_inc   (r_phase_inc),
        .i_amplitude   (r_amplitude),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_sample      (o_sample),
        .o_last_sample (o_last_sample)
    );

endmodule

`default_nettype wire
